/* hw/rtl/mmir_pkg.sv */
// ----------------------------------------------------------------------------
// mmir_pkg: shared types and constants for the min-max intensity rescaler
// Holds field widths, the configuration register codes and the control
// structs passed between the sequencer, the statistics and the divider.
// ----------------------------------------------------------------------------
package mmir_pkg;

    localparam int PIXEL_BITS_DEF = 16;
    localparam int OUT_BITS       = 16;
    localparam int CFG_BITS       = 16;
    localparam int RANGE_BITS     = CFG_BITS + 1;

    localparam logic signed [CFG_BITS-1:0] OUT_MAX_RST = 16'sd255;
    localparam logic signed [CFG_BITS-1:0] OUT_MIN_RST = 16'sd0;

    typedef enum logic [0:0] {
        CFG_OUT_MAX = 1'b0,
        CFG_OUT_MIN = 1'b1
    } mmir_cfg_idx_t;

    typedef struct packed {
        logic update;
        logic clear;
    } mmir_stat_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mmir_div_st_t;

endpackage

/* hw/rtl/mmir_if.sv */
// ----------------------------------------------------------------------------
// mmir_if: valid/ready channels of the min-max intensity rescaler
// Pixel channel into the block and result channel out of it.
// ----------------------------------------------------------------------------
interface mmir_in_if #(
    parameter int PIXEL_BITS = mmir_pkg::PIXEL_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic signed [PIXEL_BITS-1:0] pixel;
    logic                         frame_end;

    modport source (output valid, kind, pixel, frame_end, input ready);
    modport sink   (input valid, kind, pixel, frame_end, output ready);
endinterface

interface mmir_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [mmir_pkg::OUT_BITS-1:0] scaled;
    logic                                 last;

    modport source (output valid, scaled, last, input ready);
    modport sink   (input valid, scaled, last, output ready);
endinterface

/* hw/rtl/mmir_stats.sv */
// ----------------------------------------------------------------------------
// mmir_stats: running minimum and maximum of the measure pass
// Update on each measure item, return to the empty range on clear.
// ----------------------------------------------------------------------------
module mmir_stats #(
    parameter int PIXEL_BITS = mmir_pkg::PIXEL_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mmir_pkg::mmir_stat_ctl_t     ctl,
    input  logic signed [PIXEL_BITS-1:0] pixel,
    output logic signed [PIXEL_BITS-1:0] min_seen,
    output logic signed [PIXEL_BITS-1:0] max_seen
);
    import mmir_pkg::*;

    localparam logic signed [PIXEL_BITS-1:0] PIX_MAX = {1'b0, {(PIXEL_BITS-1){1'b1}}};
    localparam logic signed [PIXEL_BITS-1:0] PIX_MIN = ~PIX_MAX;

    logic signed [PIXEL_BITS-1:0] min_reg, min_next;
    logic signed [PIXEL_BITS-1:0] max_reg, max_next;

    always_comb
    begin
        min_next = min_reg;
        max_next = max_reg;
        if (ctl.clear)
        begin
            min_next = PIX_MAX;
            max_next = PIX_MIN;
        end
        else if (ctl.update)
        begin
            if (pixel < min_reg)
            begin
                min_next = pixel;
            end
            if (pixel > max_reg)
            begin
                max_next = pixel;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= PIX_MAX;
            max_reg <= PIX_MIN;
        end
        else
        begin
            min_reg <= min_next;
            max_reg <= max_next;
        end
    end

    assign min_seen = min_reg;
    assign max_seen = max_reg;

endmodule

/* hw/rtl/mmir_div.sv */
// ----------------------------------------------------------------------------
// mmir_div: signed radix-2 restoring divider
// One quotient bit per cycle on magnitudes, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module mmir_div #(
    parameter int NUM_W = mmir_pkg::PIXEL_BITS_DEF + 18,
    parameter int DEN_W = mmir_pkg::PIXEL_BITS_DEF + 1
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] num,
    input  logic signed [DEN_W-1:0] den,
    output mmir_pkg::mmir_div_st_t  status,
    output logic signed [NUM_W-1:0] quotient
);
    import mmir_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic             neg_reg, neg_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   trial_sub;

    assign trial     = {rem_reg, quo_reg[NUM_W-1]};
    assign trial_sub = trial - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            // load magnitudes, remember the sign of the quotient
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            quo_next  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
            den_next  = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
            rem_next  = '0;
            neg_next  = num[NUM_W-1] ^ den[DEN_W-1];
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial_sub[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = neg_reg ? NUM_W'(-quo_reg) : NUM_W'(quo_reg);

endmodule

/* hw/rtl/min_max_intensity_rescale_core.sv */
// ----------------------------------------------------------------------------
// min_max_intensity_rescale_core: min-max contrast stretch of a signed image
// Measure pass items track the pixel range; map pass items are stretched to
// the configured target range with an exact product and a shared divider.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake      payload
//  --------  ---  -------------  ------------------------------------------
//  pixels    in   valid / ready  kind, pixel[PIXEL_BITS], frame_end
//  results   out  valid / ready  scaled[16], last
//  cfg       in   cfg_we         cfg_index (0 out_max, 1 out_min), cfg_data
//
//  A measure item leaves the sequencer idle and gives no result.
//  A map item runs through accept, multiply, divider load, the divider steps
//  over the PIXEL_BITS + 18 quotient bits, the done cycle that forms the
//  sum, and a hand-off to the output register; the radix-2 divider loop, one
//  quotient bit a cycle, is the longest of these steps.
//  An empty-span map item (max equal to min) goes straight to the hand-off.
//  The output register holds a result while the sink stalls; the next item
//  is accepted meanwhile, and a new map result waits until the register frees.
//  Reset clears the sequencer, the output valid, the statistics to the empty
//  range and the target range to 0..255.
// ----------------------------------------------------------------------------
module min_max_intensity_rescale_core #(
    parameter int PIXEL_BITS = mmir_pkg::PIXEL_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    mmir_in_if.sink                          pixels,
    mmir_out_if.source                       results,
    input  logic                             cfg_we,
    input  mmir_pkg::mmir_cfg_idx_t          cfg_index,
    input  logic [mmir_pkg::CFG_BITS-1:0]    cfg_data
);
    import mmir_pkg::*;

    localparam int DIFF_W = PIXEL_BITS + 1;
    localparam int PROD_W = DIFF_W + RANGE_BITS;

    localparam logic signed [PIXEL_BITS-1:0] PIX_MAX = {1'b0, {(PIXEL_BITS-1){1'b1}}};
    localparam logic signed [PIXEL_BITS-1:0] PIX_MIN = ~PIX_MAX;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_MUL   = 5'b00010,
        S_START = 5'b00100,
        S_DIV   = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // target range, to be written only while idle; the block never checks
    logic signed [CFG_BITS-1:0] out_max_reg;
    logic signed [CFG_BITS-1:0] out_min_reg;

    // operands captured at accept, then the product and the result
    logic signed [DIFF_W-1:0]     diff_reg, diff_next;
    logic signed [DIFF_W-1:0]     span_reg, span_next;
    logic signed [RANGE_BITS-1:0] range_reg, range_next;
    logic signed [PROD_W-1:0]     prod_reg, prod_next;
    logic signed [OUT_BITS-1:0]   res_reg, res_next;
    logic                         last_reg, last_next;

    // output register
    logic                       out_valid_reg, out_valid_next;
    logic signed [OUT_BITS-1:0] scaled_reg, scaled_next;
    logic                       out_last_reg, out_last_next;

    logic                         acc;
    logic                         out_free;
    mmir_stat_ctl_t               stat_ctl;
    mmir_div_st_t                 div_st;
    logic                         div_start;
    logic signed [PROD_W-1:0]     quotient;
    logic signed [PIXEL_BITS-1:0] min_seen;
    logic signed [PIXEL_BITS-1:0] max_seen;
    logic signed [DIFF_W-1:0]     span_now;

    assign pixels.ready = (state_reg == S_IDLE);
    assign acc          = pixels.valid && pixels.ready;
    assign out_free     = !out_valid_reg || results.ready;
    assign span_now     = {max_seen[PIXEL_BITS-1], max_seen} - {min_seen[PIXEL_BITS-1], min_seen};

    // measure items widen the range; the last map item of a frame empties it
    assign stat_ctl.update = acc && !pixels.kind;
    assign stat_ctl.clear  = acc && pixels.kind && pixels.frame_end;

    mmir_stats #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_stats (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (stat_ctl),
        .pixel    (pixels.pixel),
        .min_seen (min_seen),
        .max_seen (max_seen)
    );

    assign div_start = (state_reg == S_START);

    mmir_div #(
        .NUM_W (PROD_W),
        .DEN_W (DIFF_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (prod_reg),
        .den      (span_reg),
        .status   (div_st),
        .quotient (quotient)
    );

    // sequencer and datapath
    always_comb
    begin
        state_next     = state_reg;
        diff_next      = diff_reg;
        span_next      = span_reg;
        range_next     = range_reg;
        prod_next      = prod_reg;
        res_next       = res_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        scaled_next    = scaled_reg;
        out_last_next  = out_last_reg;

        // drop the result once the sink takes it
        if (results.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (acc && pixels.kind)
                begin
                    // snapshot the statistics before they are cleared
                    diff_next  = {pixels.pixel[PIXEL_BITS-1], pixels.pixel}
                               - {min_seen[PIXEL_BITS-1], min_seen};
                    span_next  = span_now;
                    range_next = {out_max_reg[CFG_BITS-1], out_max_reg}
                               - {out_min_reg[CFG_BITS-1], out_min_reg};
                    last_next  = pixels.frame_end;
                    res_next   = OUT_BITS'(pixels.pixel);
                    if (span_now == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                prod_next  = PROD_W'(diff_reg) * PROD_W'(range_reg);
                state_next = S_START;
            end
            S_START:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_st.done)
                begin
                    res_next   = quotient[OUT_BITS-1:0] + out_min_reg;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // hold until the output register frees
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    scaled_next    = res_reg;
                    out_last_next  = last_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg     <= diff_next;
        span_reg     <= span_next;
        range_reg    <= range_next;
        prod_reg     <= prod_next;
        res_reg      <= res_next;
        last_reg     <= last_next;
        scaled_reg   <= scaled_next;
        out_last_reg <= out_last_next;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_max_reg <= OUT_MAX_RST;
            out_min_reg <= OUT_MIN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_OUT_MAX: out_max_reg <= cfg_data;
                CFG_OUT_MIN: out_min_reg <= cfg_data;
                default:     out_max_reg <= out_max_reg;
            endcase
        end
    end

    assign results.valid  = out_valid_reg;
    assign results.scaled = scaled_reg;
    assign results.last   = out_last_reg;

    // the divider finishes only while the sequencer waits on it
    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_st.done |-> (state_reg == S_DIV))
        else $error("divider finished outside the divide state");

    // while waiting on the divider, it is running or just finished
    a_div_alive: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (div_st.busy || div_st.done))
        else $error("divide state entered with the divider idle");

    // a hand-off from the done state always presents a result
    a_handoff: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DONE) && out_free) |=> results.valid)
        else $error("result lost at hand-off");

    // the last map item of a frame empties the statistics
    a_stats_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && pixels.kind && pixels.frame_end)
        |=> ((min_seen == PIX_MAX) && (max_seen == PIX_MIN)))
        else $error("statistics not cleared at frame end");

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the min-max intensity rescale core
// Sends measure and map passes over the pixel channel, tracks the running
// range and target range alongside the block, and compares every result
// item against the stretched value the bench works out on acceptance.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mmir_pkg::*;

    localparam int PW           = PIXEL_BITS_DEF;
    localparam int CYCLE_LIMIT  = 400000;
    // Time for a map item in flight to run out, with a margin on top of it.
    localparam int DRAIN_CYCLES = PW + 32;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 640;
    localparam int MAX_GAP      = 13;

    typedef enum logic {
        KIND_MEASURE = 1'b0,
        KIND_MAP     = 1'b1
    } pix_kind_t;

    typedef struct {
        logic signed [OUT_BITS-1:0] scaled;
        logic                       last;
    } stretch_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    mmir_cfg_idx_t cfg_index;
    logic [CFG_BITS-1:0] cfg_data;

    mmir_in_if #(.PIXEL_BITS(PW)) pix_if ();
    mmir_out_if                   res_if ();

    min_max_intensity_rescale_core #(.PIXEL_BITS(PW)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixels    (pix_if),
        .results   (res_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Shadow state of the block: running range and target range.
    logic signed [PW-1:0]       min_seen;
    logic signed [PW-1:0]       max_seen;
    logic signed [CFG_BITS-1:0] tgt_max;
    logic signed [CFG_BITS-1:0] tgt_min;

    // Stretched values still owed by the block, oldest first.
    stretch_result_t scaled_q[$];

    int  errors      = 0;
    int  items_sent  = 0;
    int  cycle_count = 0;
    int  stall_left  = 0;
    bit  snd_idle_on = 1'b1;
    bit  res_idle_on = 1'b1;
    logic hold_res;
    event hold_go;

    // ------------------------------------------------------------------------
    // Reporting and prediction
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        errors++;
    endtask

    // Empty range: minimum at the top of the pixel range, maximum at the bottom.
    task automatic clear_range();
        min_seen = {1'b0, {(PW-1){1'b1}}};
        max_seen = {1'b1, {(PW-1){1'b0}}};
    endtask

    // Advance the shadow state by one accepted item and queue its result.
    // The product is exact in 64 bits, the division truncates toward zero,
    // and only the low 16 bits of the sum are kept.
    task automatic stretch_pixel(input pix_kind_t kind, input logic signed [PW-1:0] pixel,
                                 input logic frame_end);
        longint span;
        longint num;
        stretch_result_t r;
        if (kind == KIND_MEASURE)
        begin
            if (pixel > max_seen) max_seen = pixel;
            if (pixel < min_seen) min_seen = pixel;
        end
        else
        begin
            span = longint'(max_seen) - longint'(min_seen);
            if (span != 0)
                num = (longint'(pixel) - longint'(min_seen))
                      * (longint'(tgt_max) - longint'(tgt_min)) / span
                      + longint'(tgt_min);
            else
                num = longint'(pixel);
            r.scaled = num[OUT_BITS-1:0];
            r.last   = frame_end;
            scaled_q = {scaled_q, r};
            if (frame_end) clear_range();
        end
    endtask

    // ------------------------------------------------------------------------
    // Pixel channel driver; every task here starts and ends on a rising edge
    // ------------------------------------------------------------------------
    // Valid stays high on return, so a zero gap leads straight into the next
    // item without dropping it in between.
    task automatic send_pixel(input pix_kind_t kind, input logic signed [PW-1:0] pixel,
                              input logic frame_end);
        int gap;
        gap = snd_idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_if.valid     <= 1'b1;
        pix_if.kind      <= kind;
        pix_if.pixel     <= pixel;
        pix_if.frame_end <= frame_end;
        do @(posedge clk); while (!(pix_if.valid && pix_if.ready));
        items_sent++;
        stretch_pixel(kind, pixel, frame_end);
    endtask

    // Drop valid, wait until every queued result has come, then let a map
    // item that is still in flight run out.
    task automatic wait_results_done();
        pix_if.valid <= 1'b0;
        while (scaled_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Call only while the block is idle.
    task automatic write_reg(input mmir_cfg_idx_t idx, input logic signed [CFG_BITS-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_OUT_MAX) tgt_max = value;
        else                    tgt_min = value;
        @(posedge clk);
    endtask

    task automatic set_target(input logic signed [CFG_BITS-1:0] hi,
                              input logic signed [CFG_BITS-1:0] lo);
        wait_results_done();
        write_reg(CFG_OUT_MAX, hi);
        write_reg(CFG_OUT_MIN, lo);
    endtask

    // ------------------------------------------------------------------------
    // Result channel: random stalls per item, a long hold-off on request
    // ------------------------------------------------------------------------
    task automatic check_result(input logic signed [OUT_BITS-1:0] scaled, input logic last);
        stretch_result_t want;
        if (scaled_q.size() == 0)
            report_mismatch($sformatf("unexpected result scaled=%0d last=%0b", scaled, last));
        else
        begin
            want = scaled_q.pop_front();
            if (scaled !== want.scaled)
                report_mismatch($sformatf("scaled got %0d expected %0d", scaled, want.scaled));
            if (last !== want.last)
                report_mismatch($sformatf("last got %0b expected %0b", last, want.last));
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            stall_left = 0;
            res_if.ready <= 1'b0;
        end
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                check_result(res_if.scaled, res_if.last);
                stall_left = res_idle_on ? $urandom_range(0, MAX_GAP) : 0;
            end
            else if (stall_left != 0)
            begin
                stall_left--;
            end
            res_if.ready <= !hold_res && (stall_left == 0);
        end
    end

    // Hold the result channel off for the hold-off length when asked.
    initial
    begin
        hold_res = 1'b0;
        forever
        begin
            @(hold_go);
            hold_res <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_res <= 1'b0;
        end
    end

    // Guard against a hang anywhere in the run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------
    // Stretch the full pixel range into the reset target range.
    task automatic test_full_scale();
        send_pixel(KIND_MEASURE, -16'sd32768, 1'b0);
        send_pixel(KIND_MEASURE, 16'sd32767, 1'b0);
        send_pixel(KIND_MEASURE, 16'sd100, 1'b1);   // frame end in measure: no effect
        send_pixel(KIND_MAP, -16'sd32768, 1'b0);
        send_pixel(KIND_MAP, 16'sd32767, 1'b0);
        send_pixel(KIND_MAP, 16'sd100, 1'b1);
    endtask

    // Map with the statistics still empty: negative divisor, so the mapping runs inverted.
    task automatic test_map_unmeasured();
        send_pixel(KIND_MAP, 16'sd0, 1'b0);
        send_pixel(KIND_MAP, 16'sd32767, 1'b1);
    endtask

    // Flat frame: max equals min, so pixels pass through unchanged.
    task automatic test_flat_frame();
        send_pixel(KIND_MEASURE, 16'sd1234, 1'b1);
        send_pixel(KIND_MAP, 16'sd1234, 1'b0);
        send_pixel(KIND_MAP, -16'sd5, 1'b1);
    endtask

    // Map pixels far outside a narrow measured range: the result wraps.
    task automatic test_outside_range();
        send_pixel(KIND_MEASURE, 16'sd0, 1'b0);
        send_pixel(KIND_MEASURE, 16'sd1, 1'b1);
        send_pixel(KIND_MAP, 16'sd32767, 1'b0);
        send_pixel(KIND_MAP, -16'sd32768, 1'b1);
    endtask

    // Target range with out_max below out_min inverts the mapping.
    task automatic test_reversed_target();
        set_target(-16'sd100, 16'sd200);
        send_pixel(KIND_MEASURE, -16'sd300, 1'b0);
        send_pixel(KIND_MEASURE, 16'sd700, 1'b1);
        send_pixel(KIND_MAP, -16'sd300, 1'b0);
        send_pixel(KIND_MAP, 16'sd700, 1'b1);
    endtask

    // A measure item inside a map pass widens the range for later map items.
    task automatic test_measure_mid_map();
        send_pixel(KIND_MEASURE, 16'sd10, 1'b0);
        send_pixel(KIND_MEASURE, 16'sd50, 1'b0);
        send_pixel(KIND_MAP, 16'sd30, 1'b0);
        send_pixel(KIND_MEASURE, 16'sd90, 1'b0);
        send_pixel(KIND_MAP, 16'sd90, 1'b1);
    endtask

    // Hold results off while the sender keeps offering items back to back,
    // so the output register and the datapath fill and the input stalls.
    task automatic test_backpressure();
        logic signed [PW-1:0] pix[$];
        int i;
        set_target(16'sd1000, -16'sd1000);
        snd_idle_on = 1'b0;
        -> hold_go;
        for (i = 0; i < 10; i++) pix = {pix, PW'($urandom)};
        for (i = 0; i < 10; i++) send_pixel(KIND_MEASURE, pix[i], i == 9);
        for (i = 0; i < 10; i++) send_pixel(KIND_MAP, pix[i], i == 9);
        wait_results_done();
        snd_idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Random frames
    // ------------------------------------------------------------------------
    task automatic pick_target(input int phase);
        logic signed [CFG_BITS-1:0] v;
        v = CFG_BITS'($urandom);
        case (phase % 6)
            0:       set_target(OUT_MAX_RST, OUT_MIN_RST);
            1:       set_target(16'sh7fff, 16'sh8000);
            2:       set_target(16'sh8000, 16'sh7fff);
            3:       set_target(v, v);
            default: set_target(CFG_BITS'($urandom), CFG_BITS'($urandom));
        endcase
    endtask

    // One frame: mostly a clean measure pass followed by the matching map
    // pass; the rest skips the measure pass, slips a measure item into the
    // map pass, leaves the map pass open, or is plain noise.
    task automatic run_random_frame();
        logic signed [PW-1:0] pix[$];
        logic signed [PW-1:0] base;
        logic signed [PW-1:0] val;
        int len;
        int shape;
        int flavor;
        int width;
        int slot;
        int i;
        len    = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 8);
        shape  = $urandom_range(0, 3);
        flavor = $urandom_range(0, 9);
        base   = PW'($urandom);
        width  = $urandom_range(0, 300);
        for (i = 0; i < len; i++)
        begin
            case (shape)
                0: val = PW'($urandom);
                1: val = base + PW'($urandom_range(0, width));
                2: val = base;
                default:
                    case ($urandom_range(0, 2))
                        0:       val = {1'b1, {(PW-1){1'b0}}};
                        1:       val = {1'b0, {(PW-1){1'b1}}};
                        default: val = PW'($urandom);
                    endcase
            endcase
            pix = {pix, val};
        end
        if (flavor == 9)
        begin
            for (i = 0; i < len; i++)
                send_pixel(pix_kind_t'($urandom_range(0, 1)), pix[i], 1'($urandom_range(0, 1)));
        end
        else
        begin
            if (flavor != 7)
                for (i = 0; i < len; i++) send_pixel(KIND_MEASURE, pix[i], i == len - 1);
            slot = $urandom_range(0, len - 1);
            for (i = 0; i < len; i++)
            begin
                if (flavor == 8 && i == slot) send_pixel(KIND_MEASURE, PW'($urandom), 1'b0);
                send_pixel(KIND_MAP, pix[i], (i == len - 1) && (flavor != 6));
            end
        end
    endtask

    // Each phase settles a new target range while idle, then runs frames;
    // every fourth phase runs with no idling on either side.
    task automatic test_random_frames();
        int start;
        int phase;
        start = items_sent;
        phase = 0;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            pick_target(phase);
            snd_idle_on = (phase % 4) != 3;
            res_idle_on <= (phase % 4) != 3;
            repeat (6) run_random_frame();
            phase++;
        end
        res_idle_on <= 1'b1;
        snd_idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n            = 1'b0;
        pix_if.valid     = 1'b0;
        pix_if.kind      = KIND_MEASURE;
        pix_if.pixel     = '0;
        pix_if.frame_end = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = CFG_OUT_MAX;
        cfg_data         = '0;
        tgt_max          = OUT_MAX_RST;
        tgt_min          = OUT_MIN_RST;
        clear_range();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_full_scale();
        test_map_unmeasured();
        test_flat_frame();
        test_outside_range();
        test_reversed_target();
        test_measure_mid_map();
        test_backpressure();
        test_random_frames();

        wait_results_done();
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
